// ----- design/bbhc_pkg.sv -----
// ----------------------------------------------------------------------------
// bbhc_pkg: shared types and constants of the basic block hit counter
// Field widths, item function codes, sequencer states and the table entry
// layout held in the entry memory.
// ----------------------------------------------------------------------------
package bbhc_pkg;

	localparam int WORD_W = 64;
	localparam int IDX_W  = 4;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic {
		FUNC_LOAD   = 1'b0,
		FUNC_RETIRE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		word_t range_start;
		word_t range_end;
		word_t target;
		word_t hits;
	} entry_t;

endpackage

// ----- design/basic_block_hit_counter_core.sv -----
// ----------------------------------------------------------------------------
// basic_block_hit_counter_core: hit counter for chosen basic blocks
// Holds a table of watched blocks in one synchronous memory and sweeps it
// once per item to count closed blocks and check every target.
//
// Usage:
//   Input channel: drive the item fields and raise start; the beat is taken
//   at a rising edge where start is high and busy is low. func selects a
//   table load (entry_index, range_start, range_end, target) or a retired
//   instruction event (pc, ctrl_xfer, retire_count).
//   Result channel: done is high for exactly one cycle with matched and
//   all_reached valid; the receiver takes the beat at the end of that cycle
//   and cannot stall it.
//   Timing: after the accepting edge the block walks the entry memory one
//   entry per cycle, read then write back, then passes a drain state before
//   done rises, and busy falls the cycle after done. No new item is taken
//   until busy falls.
//   Reset: clears the sequencer, the entry valid bits, the block start and
//   the last instruction count; the entry memory itself needs no clearing.
// ----------------------------------------------------------------------------
module basic_block_hit_counter_core #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic [bbhc_pkg::IDX_W-1:0]   entry_index,
	input  logic [bbhc_pkg::WORD_W-1:0]  range_start,
	input  logic [bbhc_pkg::WORD_W-1:0]  range_end,
	input  logic [bbhc_pkg::WORD_W-1:0]  target,
	input  logic [bbhc_pkg::WORD_W-1:0]  pc,
	input  logic                         ctrl_xfer,
	input  logic [bbhc_pkg::WORD_W-1:0]  retire_count,
	output logic                         done,
	output logic                         matched,
	output logic                         all_reached
);
	import bbhc_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int XW = AW + IDX_W;

	state_t          state_q;
	state_t          state_d;
	entry_t          mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	word_t           block_start_q;
	word_t           last_count_q;
	word_t           pc_q;
	logic            ctrl_q;
	logic [AW-1:0]   rd_idx_q;
	logic            match_q;
	logic            reach_q;

	entry_t          rd_data_s1;
	logic [AW-1:0]   idx_s1;
	logic            chk_s1;

	logic            accept;
	logic            load_hit;
	logic [XW-1:0]   load_idx_x;
	logic [AW-1:0]   load_addr;
	logic            last_rd;
	logic            hit_now;
	logic            inc;
	word_t           new_hits;
	logic            reached_now;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;

	assign accept     = start && !busy;
	assign load_idx_x = XW'(entry_index);
	assign load_addr  = load_idx_x[AW-1:0];
	assign load_hit   = accept && (func_t'(func) == FUNC_LOAD) &&
	                    (load_idx_x < XW'(TABLE_ENTRIES));
	assign last_rd    = (rd_idx_q == AW'(TABLE_ENTRIES - 1));

	// compare and update the entry that came back from the memory
	assign hit_now  = chk_s1 && ctrl_q && valid_q[idx_s1] &&
	                  (rd_data_s1.range_start == block_start_q) &&
	                  (rd_data_s1.range_end == pc_q);
	assign inc      = hit_now && (rd_data_s1.hits != '1);
	assign new_hits = rd_data_s1.hits + WORD_W'(inc);

	always_comb begin
		if (!valid_q[idx_s1]) begin
			reached_now = 1'b1;
		end else if (inc) begin
			reached_now = (rd_data_s1.target == '0) ||
			              (rd_data_s1.hits >= (rd_data_s1.target - WORD_W'(1)));
		end else begin
			reached_now = (rd_data_s1.hits >= rd_data_s1.target);
		end
	end

	always_comb begin
		wr_data = rd_data_s1;
		if (load_hit) begin
			wr_en               = 1'b1;
			wr_addr             = load_addr;
			wr_data.range_start = range_start;
			wr_data.range_end   = range_end;
			wr_data.target      = target;
			wr_data.hits        = '0;
		end else begin
			wr_en        = inc;
			wr_addr      = idx_s1;
			wr_data.hits = new_hits;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[rd_idx_q];
		idx_s1     <= rd_idx_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_SWEEP;
			ST_SWEEP: if (last_rd) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = (state_q != ST_IDLE);
		done        = (state_q == ST_DONE);
		matched     = match_q;
		all_reached = reach_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			valid_q       <= '0;
			block_start_q <= '0;
			last_count_q  <= '0;
			rd_idx_q      <= '0;
			chk_s1        <= 1'b0;
			match_q       <= 1'b0;
			reach_q       <= 1'b1;
			ctrl_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= (state_q == ST_SWEEP);
			if (load_hit) begin
				valid_q[load_addr] <= 1'b1;
			end
			if (accept) begin
				rd_idx_q <= '0;
				match_q  <= 1'b0;
				reach_q  <= 1'b1;
				ctrl_q   <= (func_t'(func) == FUNC_RETIRE) && ctrl_xfer;
				if (func_t'(func) == FUNC_RETIRE) begin
					last_count_q <= retire_count;
					if (retire_count == last_count_q) begin
						block_start_q <= pc;
					end
				end
			end else begin
				if (state_q == ST_SWEEP && !last_rd) begin
					rd_idx_q <= rd_idx_q + AW'(1);
				end
				if (chk_s1) begin
					match_q <= match_q || hit_now;
					reach_q <= reach_q && reached_now;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pc_q <= pc;
		end
	end

endmodule

// ----- design/bbhc_checker.sv -----
// ----------------------------------------------------------------------------
// bbhc_checker: port-level checks of the basic block hit counter
// Watches the command and result handshakes of the top level over time.
// ----------------------------------------------------------------------------
module bbhc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic matched
);

	// hold busy once a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after accepted beat");

	// drop busy right after the result beat
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("busy or done held after result beat");

	// result beats only while busy
	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat outside busy");

	// no result on the cycle after an accept
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result beat too early");

	// matched carries a known value on every result beat
	a_matched_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(matched))
		else $error("matched unknown on result beat");

endmodule

bind basic_block_hit_counter_core bbhc_checker u_bbhc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.matched (matched)
);
